/* hw/rtl/structured_light_depth_triangulation_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the triangulation block
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef STRUCTURED_LIGHT_DEPTH_TRIANGULATION_DEFINES_SVH
`define STRUCTURED_LIGHT_DEPTH_TRIANGULATION_DEFINES_SVH

// implication checked on every clock, off during reset
`define SLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/sldt_pkg.sv */
// ----------------------------------------------------------------------------
// sldt_pkg
// Types, register indexes and constants for depth triangulation.
// ----------------------------------------------------------------------------
`default_nettype none
package sldt_pkg;

    localparam int IMAGE_WIDTH_DEF  = 2048;
    localparam int IMAGE_HEIGHT_DEF = 2048;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int DIV_W            = 66;
    localparam logic [30:0] DEPTH_LIMIT_RESET = 31'(800 << 16);

    localparam logic [CFG_INDEX_W-1:0] REG_CAM_FOCAL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAM_CENTER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROJ       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_AB    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW1_CT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_AB    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW3_CT    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT      = 3'd7;

    typedef struct packed {
        logic [10:0] pixel_col;
        logic [10:0] pixel_row;
        logic        mask_bit;
        logic [19:0] proj_col;
    } pixel_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic               point_valid;
    } point_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/structured_light_depth_triangulation.sv */
// ----------------------------------------------------------------------------
// structured_light_depth_triangulation
// Camera/projector ray-plane triangulation, one pixel per clock.
// ----------------------------------------------------------------------------
// Channel  Ports                            Handshake
// pixel    start, busy, pixel               start && !busy
// point    done, point                      done, one cycle
// config   cfg_we, cfg_index, cfg_data      cfg_we
//
// One pixel enters per cycle; busy stays low, so throughput is one per cycle.
// Each pixel passes from the accepting edge to the edge that takes the point through
// the normalize dividers (u, v, s side by side), four product and sum stages,
// the depth divider, then the range check and the output register.
// rst_n clears valid bits and config registers; depth_limit resets to 800.0.
// The receiver cannot stall; results leave on done.
// ----------------------------------------------------------------------------
`default_nettype none
`include "structured_light_depth_triangulation_defines.svh"
module structured_light_depth_triangulation #(
    parameter int IMAGE_WIDTH  = sldt_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = sldt_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire sldt_pkg::pixel_t                     pixel,
    output logic                                      done,
    output sldt_pkg::point_t                          point,
    input  wire logic                                 cfg_we,
    input  wire logic [sldt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sldt_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int W = sldt_pkg::DIV_W;

    logic [63:0] reg0_reg, reg1_reg, reg2_reg, reg3_reg, reg4_reg, reg5_reg, reg6_reg;
    logic [30:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg0_reg <= '0; reg1_reg <= '0; reg2_reg <= '0; reg3_reg <= '0;
            reg4_reg <= '0; reg5_reg <= '0; reg6_reg <= '0;
            limit_reg <= sldt_pkg::DEPTH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sldt_pkg::REG_CAM_FOCAL:  reg0_reg <= cfg_data;
                sldt_pkg::REG_CAM_CENTER: reg1_reg <= cfg_data;
                sldt_pkg::REG_PROJ:       reg2_reg <= cfg_data;
                sldt_pkg::REG_ROW1_AB:    reg3_reg <= cfg_data;
                sldt_pkg::REG_ROW1_CT:    reg4_reg <= cfg_data;
                sldt_pkg::REG_ROW3_AB:    reg5_reg <= cfg_data;
                sldt_pkg::REG_ROW3_CT:    reg6_reg <= cfg_data;
                sldt_pkg::REG_LIMIT:      limit_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    logic signed [31:0] fx, fy, cx, cy, pfx, pcx, r11, r12, r13, t1, r31, r32, r33, t3;
    assign fx  = reg0_reg[63:32]; assign fy  = reg0_reg[31:0];
    assign cx  = reg1_reg[63:32]; assign cy  = reg1_reg[31:0];
    assign pfx = reg2_reg[63:32]; assign pcx = reg2_reg[31:0];
    assign r11 = reg3_reg[63:32]; assign r12 = reg3_reg[31:0];
    assign r13 = reg4_reg[63:32]; assign t1  = reg4_reg[31:0];
    assign r31 = reg5_reg[63:32]; assign r32 = reg5_reg[31:0];
    assign r33 = reg6_reg[63:32]; assign t3  = reg6_reg[31:0];

    assign busy = 1'b0;

    // stage 0: gate and form normalize numerators
    logic accept;
    logic ok0;
    assign accept = start && !busy;
    assign ok0 = pixel.mask_bit && (32'(pixel.pixel_col) < 32'(IMAGE_WIDTH))
              && (32'(pixel.pixel_row) < 32'(IMAGE_HEIGHT))
              && fx != 0 && fy != 0 && pfx != 0;

    logic signed [W-1:0] nu, nv, ns;
    assign nu = W'($signed({1'b0, pixel.pixel_col, 16'b0}) - W'(cx)) <<< 16;
    assign nv = W'($signed({1'b0, pixel.pixel_row, 16'b0}) - W'(cy)) <<< 16;
    assign ns = W'($signed({1'b0, pixel.proj_col, 8'b0}) - W'(pcx)) <<< 16;

    logic               du_v, dv_v, ds_v;
    logic signed [W-1:0] qu, qv, qs;
    logic [0:0]         ok_u, ok_v, ok_s;

    sldt_div #(.W(W), .PW(1)) u_div_u (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_num(nu), .in_den(W'(fx)),
        .in_side(ok0), .out_valid(du_v), .out_quo(qu), .out_side(ok_u));
    sldt_div #(.W(W), .PW(1)) u_div_v (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_num(nv), .in_den(W'(fy)),
        .in_side(ok0), .out_valid(dv_v), .out_quo(qv), .out_side(ok_v));
    sldt_div #(.W(W), .PW(1)) u_div_s (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_num(ns), .in_den(W'(pfx)),
        .in_side(ok0), .out_valid(ds_v), .out_quo(qs), .out_side(ok_s));

    // stage 1: saturate u, v, s; products with rotation terms
    logic               v1_reg, ok1_reg;
    logic signed [31:0] u1_reg, vv1_reg, s1_reg;
    logic signed [63:0] p31u_reg, p32v_reg, p11u_reg, p12v_reg, pt3s_reg;
    logic signed [31:0] su, sv, ss;
    assign su = sldt_pkg::sat32(qu);
    assign sv = sldt_pkg::sat32(qv);
    assign ss = sldt_pkg::sat32(qs);

    // stage 2: a, b, num
    logic               v2_reg, ok2_reg;
    logic signed [31:0] u2_reg, vv2_reg, s2_reg, a2_reg;
    logic signed [48:0] b2_reg, num2_reg;
    // stage 3: s*a
    logic               v3_reg, ok3_reg;
    logic signed [31:0] u3_reg, vv3_reg;
    logic signed [63:0] sa3_reg;
    logic signed [48:0] b3_reg, num3_reg;
    // stage 4: den
    logic               v4_reg, ok4_reg;
    logic signed [W-1:0] num4_reg, den4_reg;
    logic [63:0]        uv4_reg;

    logic signed [65:0] a_sum, b_sum;
    assign a_sum = 66'(p31u_reg >>> 16) + 66'(p32v_reg >>> 16) + 66'(r33);
    assign b_sum = 66'(p11u_reg >>> 16) + 66'(p12v_reg >>> 16) + 66'(r13);

    logic signed [65:0] den_w;
    assign den_w = 66'(sa3_reg >>> 16) - 66'(b3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= du_v; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok1_reg  <= ok_u[0] & ok_v[0] & ok_s[0];
        u1_reg   <= su; vv1_reg <= sv; s1_reg <= ss;
        p31u_reg <= r31 * su; p32v_reg <= r32 * sv;
        p11u_reg <= r11 * su; p12v_reg <= r12 * sv;
        pt3s_reg <= t3 * ss;

        ok2_reg  <= ok1_reg;
        u2_reg   <= u1_reg; vv2_reg <= vv1_reg; s2_reg <= s1_reg;
        a2_reg   <= sldt_pkg::sat32(a_sum);
        b2_reg   <= b_sum[48:0];
        num2_reg <= 49'(t1) - 49'(pt3s_reg >>> 16);

        ok3_reg  <= ok2_reg;
        u3_reg   <= u2_reg; vv3_reg <= vv2_reg;
        sa3_reg  <= s2_reg * a2_reg;
        b3_reg   <= b2_reg; num3_reg <= num2_reg;

        ok4_reg  <= ok3_reg && den_w != 0;
        uv4_reg  <= {u3_reg, vv3_reg};
        den4_reg <= den_w;
        num4_reg <= W'(num3_reg) <<< 16;
    end

    // depth divider, side carries ok, u, v
    logic               dz_v;
    logic signed [W-1:0] qz;
    logic [64:0]        side_z;

    sldt_div #(.W(W), .PW(65)) u_div_z (
        .clk(clk), .rst_n(rst_n), .in_valid(v4_reg), .in_num(num4_reg), .in_den(den4_reg),
        .in_side({ok4_reg, uv4_reg}), .out_valid(dz_v), .out_quo(qz), .out_side(side_z));

    // stage 5: range check, u*z and v*z
    logic               v5_reg, ok5_reg;
    logic [30:0]        z5_reg;
    logic signed [63:0] xz5_reg, yz5_reg;
    logic               z_ok;
    assign z_ok = side_z[64] && qz > 0 && qz < $signed({35'b0, limit_reg});

    logic signed [31:0] x_sat, y_sat;
    assign x_sat = sldt_pkg::sat32(66'(xz5_reg >>> 16));
    assign y_sat = sldt_pkg::sat32(66'(yz5_reg >>> 16));

    logic          done_reg;
    sldt_pkg::point_t point_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v5_reg   <= dz_v;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok5_reg <= z_ok;
        z5_reg  <= qz[30:0];
        xz5_reg <= $signed(side_z[63:32]) * $signed({1'b0, qz[30:0]});
        yz5_reg <= $signed(side_z[31:0]) * $signed({1'b0, qz[30:0]});
        if (ok5_reg)
        begin
            point_reg.point_x     <= x_sat;
            point_reg.point_y     <= y_sat;
            point_reg.point_z     <= z5_reg;
            point_reg.point_valid <= 1'b1;
        end
        else
        begin
            point_reg <= '0;
        end
    end

    assign done  = done_reg;
    assign point = point_reg;

    `SLT_ASSERT_IMPL(a_div_align, clk, rst_n, du_v, dv_v && ds_v)
    `SLT_ASSERT_NEXT(a_done_follow, clk, rst_n, v5_reg, done)
    `SLT_ASSERT_IMPL(a_zero_rej, clk, rst_n, done && !point.point_valid, point.point_z == '0)

endmodule
`default_nettype wire

/* hw/rtl/sldt_div.sv */
// ----------------------------------------------------------------------------
// sldt_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero. Carries a side payload alongside; a zero divisor gives zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "structured_light_depth_triangulation_defines.svh"
module sldt_div #(
    parameter int W  = 66,
    parameter int PW = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] in_num,
    input  wire logic signed [W-1:0] in_den,
    input  wire logic [PW-1:0]       in_side,
    output logic                     out_valid,
    output logic signed [W-1:0]      out_quo,
    output logic [PW-1:0]            out_side
);

    logic          vld_reg  [W+1];
    logic [W-1:0]  rem_reg  [W+1];
    logic [W-1:0]  quo_reg  [W+1];
    logic [W-1:0]  dvs_reg  [W+1];
    logic          neg_reg  [W+1];
    logic [PW-1:0] side_reg [W+1];

    logic [W-1:0] an;
    logic [W-1:0] ad;
    assign an = in_num[W-1] ? W'(-in_num) : W'(in_num);
    assign ad = in_den[W-1] ? W'(-in_den) : W'(in_den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= W; i++)
                vld_reg[i] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= W; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        quo_reg[0]  <= an;
        dvs_reg[0]  <= ad;
        neg_reg[0]  <= in_num[W-1] ^ in_den[W-1];
        side_reg[0] <= in_side;
        for (int i = 1; i <= W; i++)
        begin : stg
            logic [W:0] trial;
            trial = {rem_reg[i-1], quo_reg[i-1][W-1]} - {1'b0, dvs_reg[i-1]};
            if (!trial[W])
            begin
                rem_reg[i] <= trial[W-1:0];
                quo_reg[i] <= {quo_reg[i-1][W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[i] <= {rem_reg[i-1][W-2:0], quo_reg[i-1][W-1]};
                quo_reg[i] <= {quo_reg[i-1][W-2:0], 1'b0};
            end
            dvs_reg[i]  <= dvs_reg[i-1];
            neg_reg[i]  <= neg_reg[i-1];
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign out_valid = vld_reg[W];
    assign out_side  = side_reg[W];
    assign out_quo   = (dvs_reg[W] == '0) ? '0 :
                       (neg_reg[W] ? W'(-quo_reg[W]) : W'(quo_reg[W]));

    `SLT_ASSERT_NEXT(a_div_flow, clk, rst_n, in_valid, vld_reg[0])
    `SLT_ASSERT_IMPL(a_div_len, clk, rst_n, out_valid, $past(vld_reg[W-1]))
    `SLT_ASSERT_IMPL(a_div_zero, clk, rst_n, out_valid && dvs_reg[W] == '0, out_quo == '0)

endmodule
`default_nettype wire
